/* rtl/scv_pkg.sv */
`timescale 1ns / 1ps

package scv_pkg;

  // Record geometry
  localparam int unsigned MaxRecordBytes = 512;
  localparam int unsigned MinRecordBytes = 4;
  localparam int unsigned LenWidth       = 10;
  localparam int unsigned WordWidth      = 16;

  localparam logic [LenWidth-1:0] RecordLengthReset = LenWidth'(512);

  // Byte positions with a role of their own
  localparam logic [LenWidth-1:0] PosLengthLo = LenWidth'(0);
  localparam logic [LenWidth-1:0] PosLengthHi = LenWidth'(1);
  localparam logic [LenWidth-1:0] PosSumLo    = LenWidth'(2);
  localparam logic [LenWidth-1:0] PosSumHi    = LenWidth'(3);

  // Register map (register index taken from paddr[2])
  localparam int unsigned PaddrWidth = 3;
  localparam logic RegRecordLength = 1'b0;

  // One finished record result
  typedef struct packed {
    logic [WordWidth-1:0] computed_sum;
    logic [WordWidth-1:0] stored_sum;
    logic                 length_matches;
    logic                 sum_matches;
    logic                 record_valid;
  } result_t;

  // Handshake between accumulator and result register
  typedef struct packed {
    logic out_free;  // result register can load this cycle
  } out_ctl_t;

  typedef struct packed {
    logic take;      // staged byte consumed
    logic load;      // result produced
  } acc_ctl_t;

  // (a + b) mod 255 with a < 255 and b <= 255
  function automatic logic [7:0] mod255_add(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= 9'd255) begin
      s = s - 9'd255;
    end
    return s[7:0];
  endfunction

  // Register value clamped to the supported record length range
  function automatic logic [WordWidth-1:0] effective_length(input logic [LenWidth-1:0] len);
    logic [WordWidth-1:0] l;
    l = {{(WordWidth-LenWidth){1'b0}}, len};
    if (l < WordWidth'(MinRecordBytes)) begin
      l = WordWidth'(MinRecordBytes);
    end
    if (l > WordWidth'(MaxRecordBytes)) begin
      l = WordWidth'(MaxRecordBytes);
    end
    return l;
  endfunction

endpackage

/* rtl/settings_record_checksum_validator.sv */
`timescale 1ns / 1ps
// Channel  | Handshake                  | Payload
// ---------+----------------------------+---------------------------------------------
// input    | in_valid / in_stall        | data_byte
// output   | out_valid / out_stall      | computed_sum, stored_sum, length_matches,
//          |                            | sum_matches, record_valid
// config   | psel/penable/pwrite/pready | paddr, pwdata, prdata (record_length at 0x0)
//
// One byte per cycle while the input is not held; a byte passes an input register,
// then the mod-255 accumulators, and a record result is registered in the result register.
// Synchronous active-high reset clears record state, both valids, and sets
// record_length to 512.
// An input transfer is held only when the staged byte closes a record and the
// result register is still occupied and stalled.

module settings_record_checksum_validator
  import scv_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PaddrWidth-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            data_byte,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [15:0]           computed_sum,
  output logic [15:0]           stored_sum,
  output logic                  length_matches,
  output logic                  sum_matches,
  output logic                  record_valid
);

  logic [LenWidth-1:0] record_length;
  logic                stage_valid;
  logic [7:0]          stage_byte;
  acc_ctl_t            acc_ctl;
  out_ctl_t            out_ctl;
  result_t             result;
  result_t             out_data;

  scv_apb_regs u_regs (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .record_length (record_length)
  );

  // Input register
  assign in_stall = stage_valid && !acc_ctl.take;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (!in_stall) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      stage_byte <= data_byte;
    end
  end

  scv_accum u_accum (
    .clk           (clk),
    .rst           (rst),
    .record_length (record_length),
    .item_valid    (stage_valid),
    .item_byte     (stage_byte),
    .out_ctl       (out_ctl),
    .acc_ctl       (acc_ctl),
    .result        (result)
  );

  scv_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (acc_ctl.load),
    .result    (result),
    .out_stall (out_stall),
    .out_ctl   (out_ctl),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  assign computed_sum   = out_data.computed_sum;
  assign stored_sum     = out_data.stored_sum;
  assign length_matches = out_data.length_matches;
  assign sum_matches    = out_data.sum_matches;
  assign record_valid   = out_data.record_valid;

  a_stall_needs_byte: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> stage_valid && out_valid && out_stall)
    else $error("input stalled without a blocked closing byte");

endmodule

/* rtl/scv_apb_regs.sv */
`timescale 1ns / 1ps

module scv_apb_regs
  import scv_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PaddrWidth-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output logic [LenWidth-1:0]   record_length
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // Register write; addresses past the map are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      record_length <= RecordLengthReset;
    end else if (wr_en && (paddr[2] == RegRecordLength)) begin
      record_length <= pwdata[LenWidth-1:0];
    end
  end

  // Read mux
  always_comb begin
    prdata = '0;
    if (paddr[2] == RegRecordLength) begin
      prdata = {{(32-LenWidth){1'b0}}, record_length};
    end
  end

endmodule

/* rtl/scv_accum.sv */
`timescale 1ns / 1ps

module scv_accum
  import scv_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic [LenWidth-1:0] record_length,
  input  logic                item_valid,
  input  logic [7:0]          item_byte,
  input  out_ctl_t            out_ctl,
  output acc_ctl_t            acc_ctl,
  output result_t             result
);

  logic [LenWidth-1:0]  byte_position;
  logic [7:0]           simple_sum;
  logic [7:0]           running_sum;
  logic [WordWidth-1:0] length_word;
  logic [WordWidth-1:0] captured_sum;

  logic [WordWidth-1:0] length_word_next;
  logic [WordWidth-1:0] captured_sum_next;
  logic [7:0]           simple_sum_next;
  logic [7:0]           running_sum_next;
  logic [7:0]           term;
  logic [WordWidth-1:0] eff_len;
  logic                 last;
  logic                 length_ok;
  logic                 sum_ok;

  assign eff_len = effective_length(record_length);
  assign last    = ({{(WordWidth-LenWidth){1'b0}}, byte_position} + WordWidth'(1)) >= eff_len;

  // Header capture; checksum bytes count as zero
  always_comb begin
    length_word_next  = length_word;
    captured_sum_next = captured_sum;
    term              = item_byte;
    unique case (byte_position)
      PosLengthLo: length_word_next[7:0]   = item_byte;
      PosLengthHi: length_word_next[15:8]  = item_byte;
      PosSumLo: begin
        captured_sum_next[7:0] = item_byte;
        term                   = 8'd0;
      end
      PosSumHi: begin
        captured_sum_next[15:8] = item_byte;
        term                    = 8'd0;
      end
      default: ;
    endcase
  end

  // Fletcher-16 sums, both mod 255
  assign simple_sum_next  = mod255_add(simple_sum, term);
  assign running_sum_next = mod255_add(running_sum, simple_sum_next);

  // A closing byte needs a free result slot
  assign acc_ctl.take = item_valid && (!last || out_ctl.out_free);
  assign acc_ctl.load = item_valid && last && out_ctl.out_free;

  // Result fields
  assign length_ok             = (length_word_next == eff_len);
  assign sum_ok                = ({running_sum_next, simple_sum_next} == captured_sum_next);
  assign result.computed_sum   = {running_sum_next, simple_sum_next};
  assign result.stored_sum     = captured_sum_next;
  assign result.length_matches = length_ok;
  assign result.sum_matches    = sum_ok;
  assign result.record_valid   = length_ok && sum_ok;

  // Record state; cleared after the closing byte
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      simple_sum    <= '0;
      running_sum   <= '0;
      length_word   <= '0;
      captured_sum  <= '0;
    end else if (acc_ctl.take) begin
      if (last) begin
        byte_position <= '0;
        simple_sum    <= '0;
        running_sum   <= '0;
        length_word   <= '0;
        captured_sum  <= '0;
      end else begin
        byte_position <= byte_position + LenWidth'(1);
        simple_sum    <= simple_sum_next;
        running_sum   <= running_sum_next;
        length_word   <= length_word_next;
        captured_sum  <= captured_sum_next;
      end
    end
  end

  a_restart: assert property (@(posedge clk) disable iff (rst)
    acc_ctl.load |=> (byte_position == '0) && (simple_sum == '0) && (running_sum == '0))
    else $error("record state not cleared after closing byte");

  a_sums_reduced: assert property (@(posedge clk) disable iff (rst)
    (simple_sum != 8'hFF) && (running_sum != 8'hFF))
    else $error("running sums left unreduced");

endmodule

/* rtl/scv_out_reg.sv */
`timescale 1ns / 1ps

module scv_out_reg
  import scv_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     load,
  input  result_t  result,
  input  logic     out_stall,
  output out_ctl_t out_ctl,
  output logic     out_valid,
  output result_t  out_data
);

  assign out_ctl.out_free = !out_valid || !out_stall;

  // Result holding register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ctl.out_free) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && out_ctl.out_free) begin
      out_data <= result;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load |-> out_ctl.out_free)
    else $error("result loaded over a pending transfer");

endmodule

/* tb/sv/settings_record_checksum_validator_tb.sv */
`timescale 1ns / 1ps

import scv_pkg::*;

// Tracks the record being streamed, predicts each record result, and checks
// the results coming out of the block in order.
class record_scoreboard;
  logic [LenWidth-1:0]  reg_length;
  logic [LenWidth-1:0]  byte_pos;
  int unsigned          sum_lo;
  int unsigned          sum_hi;
  logic [WordWidth-1:0] len_word;
  logic [WordWidth-1:0] stored_word;
  result_t              expected_records[$];
  int                   fail_count;
  int                   record_count;

  function new();
    reg_length   = RecordLengthReset;
    fail_count   = 0;
    record_count = 0;
    clear_record();
  endfunction

  function void clear_record();
    byte_pos    = '0;
    sum_lo      = 0;
    sum_hi      = 0;
    len_word    = '0;
    stored_word = '0;
  endfunction

  // Register value clamped to the supported range
  function int unsigned record_bytes();
    int unsigned l;
    l = reg_length;
    if (l < MinRecordBytes) l = MinRecordBytes;
    if (l > MaxRecordBytes) l = MaxRecordBytes;
    return l;
  endfunction

  // Writes to anything but the length register are dropped
  function void write_reg(int unsigned idx, logic [31:0] value);
    if (idx == RegRecordLength) reg_length = value[LenWidth-1:0];
  endfunction

  // One accepted byte transfer
  function void absorb_byte(logic [7:0] b);
    int unsigned len;
    int unsigned term;
    result_t     r;
    len  = record_bytes();
    term = b;
    case (byte_pos)
      PosLengthLo: len_word[7:0] = b;
      PosLengthHi: len_word[15:8] = b;
      PosSumLo: begin
        stored_word[7:0] = b;
        term = 0;
      end
      PosSumHi: begin
        stored_word[15:8] = b;
        term = 0;
      end
      default: ;
    endcase
    sum_lo = (sum_lo + term) % 255;
    sum_hi = (sum_hi + sum_lo) % 255;
    // a shortened length ends the record at the first byte past it
    if (byte_pos + 1 < len) begin
      byte_pos = byte_pos + 1'b1;
    end else begin
      r.computed_sum   = {sum_hi[7:0], sum_lo[7:0]};
      r.stored_sum     = stored_word;
      r.length_matches = (len_word == len);
      r.sum_matches    = (r.computed_sum == stored_word);
      r.record_valid   = r.length_matches && r.sum_matches;
      expected_records.push_back(r);
      clear_record();
    end
  endfunction

  // One accepted result transfer
  function void check_record(result_t got);
    result_t want;
    record_count++;
    if (expected_records.size() == 0) begin
      $error("record result with none expected: computed_sum %h stored_sum %h",
             got.computed_sum, got.stored_sum);
      fail_count++;
      return;
    end
    want = expected_records.pop_front();
    if (got.computed_sum !== want.computed_sum) begin
      $error("computed_sum: expected %h, actual %h", want.computed_sum, got.computed_sum);
      fail_count++;
    end
    if (got.stored_sum !== want.stored_sum) begin
      $error("stored_sum: expected %h, actual %h", want.stored_sum, got.stored_sum);
      fail_count++;
    end
    if (got.length_matches !== want.length_matches) begin
      $error("length_matches: expected %b, actual %b", want.length_matches,
             got.length_matches);
      fail_count++;
    end
    if (got.sum_matches !== want.sum_matches) begin
      $error("sum_matches: expected %b, actual %b", want.sum_matches, got.sum_matches);
      fail_count++;
    end
    if (got.record_valid !== want.record_valid) begin
      $error("record_valid: expected %b, actual %b", want.record_valid, got.record_valid);
      fail_count++;
    end
  endfunction

  function int pending();
    return expected_records.size();
  endfunction

  function void finish_check();
    if (expected_records.size() != 0) begin
      $error("%0d record results never arrived", expected_records.size());
      fail_count++;
    end
  endfunction
endclass

module settings_record_checksum_validator_tb;

  localparam int QuietLimit     = 3000;
  localparam int SettleCycles   = 8;
  localparam int TargetBytes    = 1050;
  localparam int TargetRecords  = 40;
  localparam int HoldCycles     = 200;
  localparam int UnusedRegIndex = 1;

  typedef enum int {
    RecGood,
    RecBadLength,
    RecBadSum,
    RecUnmatchable,
    RecNoise
  } rec_kind_t;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  psel      = 1'b0;
  logic                  penable   = 1'b0;
  logic                  pwrite    = 1'b0;
  logic [PaddrWidth-1:0] paddr     = '0;
  logic [31:0]           pwdata    = '0;
  logic [31:0]           prdata;
  logic                  pready;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  logic [7:0]            data_byte = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [15:0]           computed_sum;
  logic [15:0]           stored_sum;
  logic                  length_matches;
  logic                  sum_matches;
  logic                  record_valid;

  record_scoreboard board;
  int gap_max     = 3;
  int stall_max   = 3;
  int hold_cycles = 0;
  int bytes_sent  = 0;
  int quiet_cycles = 0;

  always #4 clk = ~clk;

  settings_record_checksum_validator DUT (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .data_byte      (data_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .computed_sum   (computed_sum),
    .stored_sum     (stored_sum),
    .length_matches (length_matches),
    .sum_matches    (sum_matches),
    .record_valid   (record_valid)
  );

  // Sample transfers on both channels; watchdog on lack of progress
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) board.absorb_byte(data_byte);
      if (out_valid && !out_stall) begin
        board.check_record({computed_sum, stored_sum, length_matches, sum_matches,
                            record_valid});
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Offer one byte after a random gap and hold it until the transfer
  task automatic drive_byte(input logic [7:0] b);
    int gap;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    bytes_sent++;
  endtask

  // Stop offering and wait until every predicted result is out
  task automatic settle();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  // APB write: setup cycle, then access cycle
  task automatic set_register(input int unsigned idx, input logic [31:0] value);
    settle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PaddrWidth'(idx * 4);
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    board.write_reg(idx, value);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // Build a record for the current length and send its first count bytes
  task automatic send_record(input rec_kind_t kind, input int count);
    logic [7:0]           rec[$];
    logic [WordWidth-1:0] word;
    int unsigned          len;
    int unsigned          lo;
    int unsigned          hi;
    int unsigned          term;
    int                   i;
    len = board.record_bytes();
    for (i = 0; i < len; i++) rec.push_back(8'($urandom_range(0, 255)));
    if (kind != RecNoise) begin
      word = WordWidth'(len);
      if (kind == RecBadLength) word = word + WordWidth'($urandom_range(1, 65535));
      rec[PosLengthLo] = word[7:0];
      rec[PosLengthHi] = word[15:8];
      lo = 0;
      hi = 0;
      for (i = 0; i < len; i++) begin
        term = (i == PosSumLo || i == PosSumHi) ? 0 : rec[i];
        lo = (lo + term) % 255;
        hi = (hi + lo) % 255;
      end
      word = {hi[7:0], lo[7:0]};
      if (kind == RecBadSum) word = word ^ WordWidth'($urandom_range(1, 65535));
      // a stored byte of 255 can never be produced by the mod-255 sums
      if (kind == RecUnmatchable) begin
        case ($urandom_range(0, 2))
          0: word = 16'hFFFF;
          1: word[15:8] = 8'hFF;
          default: word[7:0] = 8'hFF;
        endcase
      end
      rec[PosSumLo] = word[7:0];
      rec[PosSumHi] = word[15:8];
    end
    for (i = 0; i < count; i++) drive_byte(rec[i]);
  endtask

  // Result side: random stall per transfer, plus one long hold on request
  initial begin : result_sink
    int wait_cycles;
    wait (rst == 1'b0);
    @(negedge clk);
    forever begin
      if (hold_cycles > 0) begin
        wait_cycles = hold_cycles;
        hold_cycles = 0;
      end else begin
        wait_cycles = $urandom_range(0, stall_max);
      end
      if (wait_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  initial begin : stimulus
    int          phase;
    int          pick;
    int          records;
    int unsigned reg_value;
    rec_kind_t   kind;

    board = new();
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Register below the minimum: clamped to four bytes
    set_register(RegRecordLength, 0);
    send_record(RecGood, 4);
    // Write to an unused register index leaves the length alone
    set_register(UnusedRegIndex, 9);
    send_record(RecUnmatchable, 4);
    // Length word holding the raw register value, then an all-ones record
    set_register(RegRecordLength, 3);
    drive_byte(8'h03);
    drive_byte(8'h00);
    drive_byte(8'h00);
    drive_byte(8'h00);
    repeat (4) drive_byte(8'hFF);
    set_register(RegRecordLength, 5);
    send_record(RecGood, 5);
    // Length shortened while a record is in progress
    set_register(RegRecordLength, 16);
    send_record(RecGood, 4);
    set_register(RegRecordLength, MinRecordBytes);
    send_record(RecNoise, 1);

    // Random phases, each with its own length and idle pattern
    phase = 0;
    while (bytes_sent < TargetBytes || board.record_count < TargetRecords) begin
      pick    = $urandom_range(0, 99);
      records = $urandom_range(1, 5);
      if (phase == 0) begin
        reg_value = 1023;
        records   = 1;
      end else if (phase == 2) begin
        reg_value = MinRecordBytes;
        records   = 12;
      end else if (pick < 10) begin
        reg_value = $urandom_range(0, 3);
      end else if (pick < 88) begin
        reg_value = $urandom_range(4, 16);
      end else begin
        reg_value = $urandom_range(17, 64);
        records   = $urandom_range(1, 2);
      end
      set_register(RegRecordLength, reg_value);
      gap_max   = ($urandom_range(0, 3) == 0) ? 0 : 12;
      stall_max = ($urandom_range(0, 3) == 0) ? 0 : 12;
      // back-to-back bytes against a long receiver hold fill the block
      if (phase == 2) begin
        gap_max     = 0;
        hold_cycles = HoldCycles;
      end
      repeat (records) begin
        pick = $urandom_range(0, 99);
        kind = (pick < 70) ? RecGood :
               (pick < 80) ? RecBadLength :
               (pick < 88) ? RecBadSum :
               (pick < 94) ? RecUnmatchable : RecNoise;
        send_record(kind, board.record_bytes());
      end
      // sometimes leave a record unfinished across the length change
      if ($urandom_range(0, 4) == 0) begin
        send_record(RecGood, $urandom_range(1, board.record_bytes() - 1));
      end
      phase++;
    end

    settle();
    board.finish_check();
    if (board.fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
